// ----- rtl/stbs_pkg.sv -----
// Package for the sorted table binary search block.
// Holds the table size, the word types of both channels, the table access struct
// and the sequencer states. It depends on nothing else.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int SLOT_W      = 10;
  localparam int VAL_W       = 32;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(TABLE_DEPTH);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_RESULT
  } seq_state_t;

endpackage

// ----- rtl/stbs_table.sv -----
// Table memory of the sorted table binary search block.
// One write port and one read port with registered read data; uses stbs_pkg.
module stbs_table
  import stbs_pkg::*;
(
  input  logic             clk,
  input  tbl_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [TABLE_DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/stbs_ctrl.sv -----
// Search sequencer of the sorted table binary search block.
// Holds the bounds, the shared compare unit and the result register; uses stbs_pkg.
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  output tbl_req_t         req,
  input  logic [VAL_W-1:0] rd_data
);

  seq_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        low_r, low_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [TBL_AW-1:0]       mid_r, mid_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic                    hit_r, hit_nxt;
  logic [SLOT_W-1:0]       pos_r, pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;
  logic [CNT_W:0]          mid_sum;
  logic signed [VAL_W-1:0] probe;
  logic                    accept;

  // The upper bound is kept exclusive, so the probe is floor((low + hi - 1) / 2).
  assign mid_sum = {1'b0, low_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign probe   = rd_data;
  assign accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    req           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_data.mode == MODE_LOAD) begin
            req.we    = (CNT_W'(in_data.slot) < MAX_COUNT);
            req.waddr = TBL_AW'(in_data.slot);
            req.wdata = in_data.value;
          end else begin
            key_nxt   = in_data.value;
            low_nxt   = '0;
            hi_nxt    = (count_r > MAX_COUNT) ? MAX_COUNT : count_r;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (low_r < hi_r) begin
          mid_nxt   = TBL_AW'(mid_sum >> 1);
          req.re    = 1'b1;
          req.raddr = TBL_AW'(mid_sum >> 1);
          state_nxt = ST_CMP;
        end else begin
          hit_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_RESULT;
        end
      end
      ST_CMP: begin
        if (probe == key_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = SLOT_W'(mid_r);
          state_nxt = ST_RESULT;
        end else if (probe < key_r) begin
          low_nxt   = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = ST_PROBE;
        end else begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = ST_PROBE;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = hit_r;
          out_data_nxt.position = pos_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> (CNT_W'(mid_r) < hi_r) && (low_r <= CNT_W'(mid_r)))
    else $error("probe slot lies outside the search bounds");

  a_bound_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> hi_r <= MAX_COUNT)
    else $error("upper bound exceeds the table depth");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result word raised outside the result state");

  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.position == '0)
    else $error("a miss must report position zero");

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// Top level of the sorted table binary search block; instantiates stbs_ctrl and
// stbs_table and uses stbs_pkg. A load word is written as it is accepted, and the next
// word may follow. A search passes the probe and compare states once per probe, at most
// 11 probes for a 1024 entry table, then a bound check on a miss and the result state,
// which waits while an earlier result is held. No new word is accepted until it is done.
// Synchronous active-low reset clears entry_count and the control state, not the table.
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  tbl_req_t         req;
  logic [VAL_W-1:0] rd_data;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .req       (req),
    .rd_data   (rd_data)
  );

  stbs_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for sorted_table_binary_search: loads sorted tables and some unsorted entries,
// searches them and checks each found flag and position against a search predictor kept
// in step with every load. Depends on stbs_pkg and the sorted_table_binary_search RTL only.
`timescale 1ns / 1ps

module tb;
  import stbs_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_GAP = 40;
  localparam longint MAX_VALUE = 64'sd2147483647;
  localparam longint MIN_VALUE = -64'sd2147483648;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;

  logic signed [VAL_W-1:0] entry_shadow [TABLE_DEPTH];
  int          count_shadow = 0;
  out_word_t   results_due [$];
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_off = 0;
  int          quiet_cycles = 0;
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_loads = 0;
  int          n_searches = 0;
  int          n_settings = 0;

  sorted_table_binary_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int effective_count();
    return (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
  endfunction

  function automatic out_word_t predict_search(input logic signed [VAL_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    out_word_t r;
    lo = 0;
    hi = effective_count() - 1;
    r = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entry_shadow[mid] == key) begin
        r.found = 1'b1;
        r.position = SLOT_W'(mid);
        return r;
      end
      if (entry_shadow[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (in_data.mode == MODE_LOAD) begin
        entry_shadow[in_data.slot] = in_data.value;
        n_loads++;
      end else begin
        results_due.push_back(predict_search(in_data.value));
        n_searches++;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result word, position", out_data.position, -1);
      end else begin
        want = results_due.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.position !== want.position)
          report_mismatch("position", out_data.position, want.position);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_load(input int slot, input logic signed [VAL_W-1:0] value);
    in_word_t w;
    w.mode = MODE_LOAD;
    w.slot = SLOT_W'(slot);
    w.value = value;
    send_word(w);
  endtask

  task automatic send_search(input logic signed [VAL_W-1:0] key);
    in_word_t w;
    w.mode = MODE_SEARCH;
    w.slot = SLOT_W'($urandom());
    w.value = key;
    send_word(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(input int n);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CNT_W'(n);
    @(posedge clk);
    count_shadow = n;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic load_sorted_run(input int n, input longint start, input int stride_log);
    longint v;
    v = start;
    for (int s = 0; s < n; s++) begin
      if (v > MAX_VALUE) v = MAX_VALUE;
      send_load(s, VAL_W'(v));
      if ($urandom_range(9) != 0) v += $urandom_range(32'd1 << stride_log, 1);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_key();
    int                      eff;
    int                      sel;
    logic signed [VAL_W-1:0] k;
    eff = effective_count();
    sel = $urandom_range(9);
    k = $urandom();
    if (eff > 0 && sel < 6) k = entry_shadow[$urandom_range(eff - 1)];
    else if (eff > 0 && sel < 8) k = entry_shadow[$urandom_range(eff - 1)] + ((sel == 6) ? 1 : -1);
    return k;
  endfunction

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_entry_count(0);
    send_search(0);
    send_search(32'sh8000_0000);
    send_load(0, 32'sh8000_0000);
    send_load(1, -1000);
    send_load(2, -1);
    send_load(3, 0);
    send_load(4, 1);
    send_load(5, 5);
    send_load(6, 1000);
    send_load(7, 32'sh7FFF_FFFF);
    send_load(1023, 32'sh5555_AAAA);
    set_entry_count(8);
    send_search(32'sh8000_0000);
    send_search(32'sh7FFF_FFFF);
    send_search(0);
    send_search(2);
    send_search(32'sh8000_0001);
    send_search(5);
    set_entry_count(1);
    send_search(32'sh8000_0000);
    send_search(32'sh7FFF_FFFF);
    send_load(2, 32'sh7FFF_FFFF);
    set_entry_count(8);
    send_search(-1);
    send_search(1000);
  endtask

  task automatic test_full_table();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    load_sorted_run(TABLE_DEPTH, MIN_VALUE + $urandom_range(1000), 22);
    set_entry_count(TABLE_DEPTH);
    repeat (30) send_search(pick_key());
    set_entry_count(2047);
    repeat (20) send_search(pick_key());
    set_entry_count(1023);
    repeat (10) send_search(pick_key());
    set_entry_count(1025);
    repeat (10) send_search(pick_key());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_entry_count(TABLE_DEPTH);
    hold_off = HOLD_OFF_CYCLES;
    repeat (24) send_search(pick_key());
    wait_drained();
    receiver_stall_pct = 62;
    repeat (20) send_search(pick_key());
  endtask

  task automatic run_traffic_phase(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int sel;
    int count;
    int eff;
    sent = 0;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (sent < n_items) begin
      sel = $urandom_range(19);
      if (sel == 0) count = 0;
      else if (sel == 1) count = $urandom_range(2047, TABLE_DEPTH + 1);
      else if (sel == 2) count = TABLE_DEPTH;
      else count = $urandom_range(48, 1);
      set_entry_count(count);
      eff = effective_count();
      if (eff > 0 && eff <= 48) begin
        load_sorted_run(eff, longint'($signed($urandom())) / 2, $urandom_range(26));
        sent += eff;
      end
      repeat ($urandom_range(16, 4)) begin
        if ($urandom_range(7) == 0) begin
          send_load($urandom_range(TABLE_DEPTH - 1), $urandom());
          sent++;
        end
        send_search(pick_key());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 100);
    run_traffic_phase(62, 0, 100);
    run_traffic_phase(0, 62, 100);
    run_traffic_phase(20, 20, 100);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    $display("Checked %0d search results over %0d loads and %0d searches, %0d count settings.",
             n_checked, n_loads, n_searches, n_settings);
    $display("Covered empty, single, full and over-depth tables, unsorted entries and stalls.");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sorted_table_binary_search.f -----
rtl/stbs_pkg.sv
rtl/stbs_table.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
tb/sv/tb.sv
